/* hw/rtl/hmss_pkg.sv */
// Shared types, constants and the rank compare for the hit merge score sorter.
`timescale 1ns / 1ps
package hmss_pkg;

	localparam int CAPACITY  = 64;
	localparam int SOURCES   = 4;
	localparam int ID_BITS   = 24;
	localparam int NUM_BASES = 4;

	localparam int SCORE_W   = 32;
	localparam int GID_W     = 24;
	localparam int LID_W     = 24;
	localparam int SRC_W     = 2;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int SUM_W     = GID_W + 1;

	// saturation limit, kept as 32 bits so ID_BITS up to 31 fits
	localparam logic [31:0] ID_LIMIT = 32'((64'd1 << ID_BITS) - 64'd1);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [GID_W-1:0]   gid;
		logic [LID_W-1:0]   lid;
		logic [SRC_W-1:0]   src;
	} hit_t;

	typedef struct packed {
		logic insert;  // place broadcast hit, shift lower ranks down
		logic shift;   // move every entry one place toward the head
	} cell_ctrl_t;

	// a ranks strictly before b: higher score, then lower global id
	function automatic logic ranks_before(input hit_t a, input hit_t b);
		logic r;
		if (a.score != b.score)
			r = a.score > b.score;
		else
			r = a.gid < b.gid;
		return r;
	endfunction

endpackage

/* hw/rtl/hmss_id_map.sv */
// Per-source document base registers and global id forming with saturation.
`timescale 1ns / 1ps
module hmss_id_map (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hmss_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [hmss_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [hmss_pkg::SRC_W-1:0]      src,
	input  logic [hmss_pkg::LID_W-1:0]      lid,
	output logic [hmss_pkg::GID_W-1:0]      gid,
	output logic                            sat,
	output logic                            src_ok
);
	import hmss_pkg::*;

	logic [CFG_W-1:0] base_q [NUM_BASES];
	logic [SUM_W-1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BASES; i++)
				base_q[i] <= '0;
		end else if (cfg_we) begin
			base_q[cfg_addr] <= cfg_wdata;
		end
	end

	always_comb begin
		src_ok = (32'(src) < SOURCES) && (32'(src) < NUM_BASES);
		sum    = SUM_W'(base_q[src]) + SUM_W'(lid);
		sat    = 32'(sum) > ID_LIMIT;
		gid    = sat ? ID_LIMIT[GID_W-1:0] : sum[GID_W-1:0];
	end

endmodule

/* hw/rtl/hmss_cell.sv */
// One slot of the sorted insertion chain.
`timescale 1ns / 1ps
module hmss_cell (
	input  logic                    clk,
	input  hmss_pkg::cell_ctrl_t    ctrl,
	input  logic                    occupied,
	input  hmss_pkg::hit_t          new_hit,
	input  hmss_pkg::hit_t          prev_hit,
	input  logic                    prev_ahead,
	input  hmss_pkg::hit_t          next_hit,
	output hmss_pkg::hit_t          hit_q,
	output logic                    new_ahead
);
	import hmss_pkg::*;

	// empty slots always lose, so the ahead flags form a thermometer down the chain
	assign new_ahead = !occupied || ranks_before(new_hit, hit_q);

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (prev_ahead)
				hit_q <= prev_hit;
			else if (new_ahead)
				hit_q <= new_hit;
		end else if (ctrl.shift) begin
			hit_q <= next_hit;
		end
	end

endmodule

/* hw/rtl/hit_merge_score_sorter_top.sv */
// Top level: input stage, insertion chain of hit cells, emit control and output register.
//
//  channel   | dir | handshake          | payload
//  s_*       | in  | s_tvalid/s_tready  | s_tuser command, s_tdata: source, local_id, hit_score
//  m_*       | out | m_tvalid/m_tready  | m_tdata, m_tuser hit_valid, m_tlast last
//  cfg_*     | in  | cfg_we             | cfg_addr base index, cfg_wdata base value
//
// A load item has its id formed in the input register stage, and in the cycle after the
// hit is placed by all chain cells at once, so loads stream back to back. A finish item
// switches to emit; the chain then shifts toward the head, one result per cycle into the
// output register while m_tready does not stall it, N results for N stored hits (one for
// an empty store). Input is held off from the finish until the last result is in the
// output register. Reset clears control state and bases only; no clearing pass is needed.
`timescale 1ns / 1ps
module hit_merge_score_sorter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [1:0] source, [25:2] local_id, [57:26] hit_score, [63:58] zero
	input  logic [63:0]                     s_tdata,
	// [0] command
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [23:0] gid, [55:24] out_score, [57:56] out_source, [81:58] out_local_id,
	// [82] overflow, [87:83] zero
	output logic [87:0]                     m_tdata,
	// [0] hit_valid
	output logic                            m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [hmss_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [hmss_pkg::CFG_W-1:0]      cfg_wdata
);
	import hmss_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	logic             in_cmd;
	logic [SRC_W-1:0] in_src;
	logic [LID_W-1:0] in_lid;
	logic [SCORE_W-1:0] in_score;
	logic [GID_W-1:0] in_gid;
	logic             in_sat;
	logic             in_src_ok;
	logic             s_accept;

	logic             valid_s1;
	logic             cmd_s1;
	logic             sat_s1;
	logic             srcok_s1;
	hit_t             hit_s1;

	logic             full;
	logic             load_go;
	logic             out_load;
	cell_ctrl_t       ctrl;

	hit_t             cell_hit [CAPACITY];
	logic             ahead_v [CAPACITY];

	logic             out_valid_q;
	hit_t             out_hit_q;
	logic             out_hv_q;
	logic             out_last_q;
	logic             out_ovf_q;

	assign in_cmd   = s_tuser;
	assign in_src   = s_tdata[1:0];
	assign in_lid   = s_tdata[25:2];
	assign in_score = s_tdata[57:26];

	hmss_id_map u_id_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.src       (in_src),
		.lid       (in_lid),
		.gid       (in_gid),
		.sat       (in_sat),
		.src_ok    (in_src_ok)
	);

	assign s_tready = (state_q == ST_LOAD) && !(valid_s1 && cmd_s1 == CMD_FINISH);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= s_accept;
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1       <= in_cmd;
			sat_s1       <= in_sat;
			srcok_s1     <= in_src_ok;
			hit_s1.score <= in_score;
			hit_s1.gid   <= in_gid;
			hit_s1.lid   <= in_lid;
			hit_s1.src   <= in_src;
		end
	end

	assign full     = count_q == CNT_W'(CAPACITY);
	assign load_go  = (state_q == ST_LOAD) && valid_s1 && cmd_s1 == CMD_LOAD && srcok_s1;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	always_comb begin
		ctrl.insert = load_go;
		ctrl.shift  = out_load && count_q != '0;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		hit_t pv_hit;
		hit_t nx_hit;
		logic pv_ahead;

		if (i == 0) begin : g_head
			assign pv_hit   = hit_s1;
			assign pv_ahead = 1'b0;
		end else begin : g_mid
			assign pv_hit   = cell_hit[i-1];
			assign pv_ahead = ahead_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign nx_hit = cell_hit[i];
		end else begin : g_body
			assign nx_hit = cell_hit[i+1];
		end

		hmss_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CNT_W'(i)),
			.new_hit     (hit_s1),
			.prev_hit    (pv_hit),
			.prev_ahead  (pv_ahead),
			.next_hit    (nx_hit),
			.hit_q       (cell_hit[i]),
			.new_ahead   (ahead_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (valid_s1) begin
						if (cmd_s1 == CMD_FINISH) begin
							state_q <= ST_EMIT;
						end else if (!srcok_s1) begin
							ovf_q <= 1'b1;
						end else begin
							if (sat_s1 || full)
								ovf_q <= 1'b1;
							if (!full)
								count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (count_q <= CNT_W'(1)) begin
							state_q <= ST_LOAD;
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hv_q   <= count_q != '0;
			out_hit_q  <= (count_q != '0) ? cell_hit[0] : '0;
			out_last_q <= count_q <= CNT_W'(1);
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hv_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'b0, out_ovf_q, out_hit_q.lid, out_hit_q.src,
		out_hit_q.score, out_hit_q.gid};

	// store never holds more than its capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("hit count above capacity");

	// a load into a full chain leaves the count unchanged
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		load_go && full |=> count_q == CNT_W'(CAPACITY))
		else $error("count moved on full insert");

	// final result of a run returns the block to loading with an empty store
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && count_q <= CNT_W'(1) |=> state_q == ST_LOAD && count_q == '0 && !ovf_q)
		else $error("emit run did not close");

	// no input is taken while emitting
	a_emit_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !s_tready)
		else $error("input accepted during emit");

endmodule

/* tb/sv/hit_merge_score_sorter_top_test.sv */
// Self-checking test of the hit merge score sorter: ranked-hit scoreboard and stream drivers.
`timescale 1ns / 1ps
module hit_merge_score_sorter_top_test;

	localparam int          STORE_DEPTH = 64;
	localparam logic [24:0] GID_MAX     = 25'h0FFFFFF;
	localparam int          ITEM_TARGET = 370;
	localparam int          LONG_HOLD   = 300;
	localparam int          SETTLE      = 8;
	localparam longint      LIMIT_NS    = 64'd12 * 64'd400000;

	typedef enum logic [1:0] {
		REG_BASE_SRC0,
		REG_BASE_SRC1,
		REG_BASE_SRC2,
		REG_BASE_SRC3
	} base_reg_e;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

	typedef struct packed {
		logic        hit_valid;
		logic [23:0] gid;
		logic [31:0] score;
		logic [1:0]  src;
		logic [23:0] lid;
		logic        ovf;
		logic        last;
	} ranked_result_t;

	// Keeps the ranked hit list as the block should hold it and the results still owed.
	class ranked_hit_board;
		logic [23:0]      base_of [4];
		hmss_pkg::hit_t   ranked_hits[$];
		ranked_result_t   due_results[$];
		logic             ovf_seen;
		int               mismatches;
		int               loads;
		int               finishes;
		int               results_checked;
		int               dropped;
		int               saturated;

		function new();
			foreach (base_of[i])
				base_of[i] = '0;
			ovf_seen        = 1'b0;
			mismatches      = 0;
			loads           = 0;
			finishes        = 0;
			results_checked = 0;
			dropped         = 0;
			saturated       = 0;
		endfunction

		function void set_base(base_reg_e idx, logic [23:0] value);
			base_of[idx] = value;
		endfunction

		// higher score first, then lower global id; equal hits keep arrival order
		function bit outranks(hmss_pkg::hit_t a, hmss_pkg::hit_t b);
			if (a.score != b.score)
				return a.score > b.score;
			return a.gid < b.gid;
		endfunction

		function void note_item(logic cmd, logic [1:0] src, logic [23:0] lid,
				logic [31:0] score);
			hmss_pkg::hit_t h;
			ranked_result_t r;
			logic [24:0]    sum;
			int             pos;
			if (cmd == hmss_pkg::CMD_FINISH) begin
				finishes++;
				r      = '0;
				r.ovf  = ovf_seen;
				r.last = 1'b1;
				if (ranked_hits.size() == 0)
					due_results.insert(due_results.size(), r);
				foreach (ranked_hits[k]) begin
					r.hit_valid = 1'b1;
					r.gid       = ranked_hits[k].gid;
					r.score     = ranked_hits[k].score;
					r.src       = ranked_hits[k].src;
					r.lid       = ranked_hits[k].lid;
					r.last      = (k == ranked_hits.size() - 1);
					due_results.insert(due_results.size(), r);
				end
				ranked_hits.delete();
				ovf_seen = 1'b0;
				return;
			end
			loads++;
			sum = {1'b0, base_of[src]} + {1'b0, lid};
			if (sum > GID_MAX) begin
				sum = GID_MAX;
				ovf_seen = 1'b1;
				saturated++;
			end
			h.score = score;
			h.gid   = sum[23:0];
			h.lid   = lid;
			h.src   = src;
			pos = 0;
			while (pos < ranked_hits.size() && !outranks(h, ranked_hits[pos]))
				pos++;
			if (ranked_hits.size() >= STORE_DEPTH) begin
				// full store: the lowest ranked of old hits plus the new one falls out
				ovf_seen = 1'b1;
				dropped++;
				if (pos >= STORE_DEPTH)
					return;
				void'(ranked_hits.pop_back());
			end
			ranked_hits.insert(pos, h);
		endfunction

		function void check_result(logic [87:0] data, logic hv, logic lst);
			ranked_result_t got;
			ranked_result_t want;
			got.hit_valid = hv;
			got.gid       = data[23:0];
			got.score     = data[55:24];
			got.src       = data[57:56];
			got.lid       = data[81:58];
			got.ovf       = data[82];
			got.last      = lst;
			results_checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hv=%0d gid=%h score=%h src=%0d lid=%h ovf=%0d last=%0d",
						got.hit_valid, got.gid, got.score, got.src, got.lid, got.ovf, got.last);
				return;
			end
			want = due_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d mismatch at %0t", results_checked, $time);
					$display("  expected hv=%0d gid=%h score=%h src=%0d lid=%h ovf=%0d last=%0d",
						want.hit_valid, want.gid, want.score, want.src, want.lid, want.ovf,
						want.last);
					$display("  actual   hv=%0d gid=%h score=%h src=%0d lid=%h ovf=%0d last=%0d",
						got.hit_valid, got.gid, got.score, got.src, got.lid, got.ovf, got.last);
				end
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [87:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_addr  = '0;
	logic [23:0] cfg_wdata = '0;

	ranked_hit_board board;
	int              items_sent    = 0;
	int              burst_left    = 0;
	int              base_settings = 0;
	int              hold_requests = 0;
	int              hold_served   = 0;
	int              hold_left     = 0;
	int              ready_tick    = 0;
	rx_mode_e        ready_mode    = RX_OPEN;

	hit_merge_score_sorter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: changing stall pattern, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = LONG_HOLD;
		end
		ready_tick++;
		if (ready_tick % 97 == 0)
			ready_mode = rx_mode_e'($urandom_range(0, 3));
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (ready_mode)
			RX_OPEN: begin
				m_tready <= 1'b1;
			end
			RX_COIN: begin
				m_tready <= ($urandom_range(0, 1) == 1);
			end
			RX_SPARSE: begin
				m_tready <= (ready_tick % 4 == 0);
			end
			default: begin
				m_tready <= ($urandom_range(0, 7) != 0);
			end
			endcase
		end
	end

	// inputs change only at rising edges, so the falling edge sees settled handshakes
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser, m_tlast);
	end

	task automatic offer(input logic cmd, input logic [1:0] src, input logic [23:0] lid,
			input logic [31:0] score);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'd0, score, lid, src};
		do
			@(negedge clk);
		while (!s_tready);
		board.note_item(cmd, src, lid, score);
		@(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(0, 20);
		end
	endtask

	task automatic write_reg(input base_reg_e idx, input logic [23:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		board.set_base(idx, value);
	endtask

	task automatic set_bases(input logic [23:0] b0, input logic [23:0] b1,
			input logic [23:0] b2, input logic [23:0] b3);
		write_reg(REG_BASE_SRC0, b0);
		write_reg(REG_BASE_SRC1, b1);
		write_reg(REG_BASE_SRC2, b2);
		write_reg(REG_BASE_SRC3, b3);
		cfg_we <= 1'b0;
		base_settings++;
	endtask

	// loads leave no trace in the result count, so wait after the last result for the chain to settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	function automatic logic [23:0] pick_base();
		case ($urandom_range(0, 4))
		0: return 24'h000000;
		1: return 24'hFFFFFF;
		2: return 24'($urandom_range(0, 255));
		3: return 24'hFFFFFF - 24'($urandom_range(0, 4095));
		default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic [23:0] pick_lid();
		case ($urandom_range(0, 3))
		0: return 24'($urandom_range(0, 15));
		1: return 24'hFFFFFF - 24'($urandom_range(0, 15));
		default: return 24'($urandom());
		endcase
	endfunction

	// mode 0 draws from two values so ties in score are common
	function automatic logic [31:0] pick_score(input int mode, input logic [31:0] tie);
		case (mode)
		0: return ($urandom_range(0, 1) == 1) ? tie : tie ^ 32'h0001_0000;
		1: return ($urandom_range(0, 1) == 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
		2: return 32'($urandom_range(0, 3)) << 16;
		default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int          runs;
		int          n;
		int          run_no;
		int          score_mode;
		logic [31:0] tie;
		board = new();
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bases still at reset: same global id from two sources, ties, field extremes
		offer(hmss_pkg::CMD_FINISH, 2'd0, 24'h000000, 32'h0000_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd0, 24'h000005, 32'h0001_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd1, 24'h000005, 32'h0001_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd2, 24'h000003, 32'h0001_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd3, 24'hFFFFFF, 32'hFFFF_FFFF);
		offer(hmss_pkg::CMD_LOAD, 2'd0, 24'h000000, 32'h0000_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd1, 24'hAAAAAA, 32'h5555_5555);
		offer(hmss_pkg::CMD_LOAD, 2'd2, 24'h555555, 32'hAAAA_AAAA);
		offer(hmss_pkg::CMD_FINISH, 2'd3, 24'hFFFFFF, 32'hFFFF_FFFF);
		wait_idle();

		// bases at the extremes: ids right at the top of the range and just past it
		set_bases(24'h000000, 24'hFFFFFF, 24'h800000, 24'h000001);
		offer(hmss_pkg::CMD_LOAD, 2'd1, 24'h000000, 32'h0000_0007);
		offer(hmss_pkg::CMD_FINISH, 2'd0, 24'h000000, 32'h0000_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd1, 24'h000001, 32'h0000_0007);
		offer(hmss_pkg::CMD_LOAD, 2'd2, 24'h7FFFFF, 32'h0000_0009);
		offer(hmss_pkg::CMD_LOAD, 2'd2, 24'h800000, 32'h0000_0009);
		offer(hmss_pkg::CMD_LOAD, 2'd3, 24'hFFFFFE, 32'h8000_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd3, 24'hFFFFFF, 32'h8000_0000);
		offer(hmss_pkg::CMD_LOAD, 2'd0, 24'h123456, 32'h0000_0009);
		offer(hmss_pkg::CMD_FINISH, 2'd0, 24'h000000, 32'h0000_0000);
		offer(hmss_pkg::CMD_FINISH, 2'd2, 24'h5A5A5A, 32'hDEAD_BEEF);

		run_no = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			set_bases(pick_base(), pick_base(), pick_base(), pick_base());
			runs = $urandom_range(1, 3);
			for (int r = 0; r < runs; r++) begin
				run_no++;
				if (run_no == 3)
					n = $urandom_range(66, 80);
				else if ($urandom_range(0, 11) == 0)
					n = $urandom_range(56, 72);
				else if ($urandom_range(0, 9) == 0)
					n = 0;
				else
					n = $urandom_range(1, 16);
				score_mode = $urandom_range(0, 3);
				tie        = $urandom();
				for (int i = 0; i < n; i++)
					offer(hmss_pkg::CMD_LOAD, 2'($urandom_range(0, 3)), pick_lid(),
						pick_score(score_mode, tie));
				// overflowing run: stall the output so its emit backs up into the input
				if (run_no == 3)
					hold_requests++;
				offer(hmss_pkg::CMD_FINISH, 2'($urandom_range(0, 3)), pick_lid(),
					$urandom());
				// keep offering while the stalled emit holds the input off
				if (run_no == 3)
					offer(hmss_pkg::CMD_LOAD, 2'($urandom_range(0, 3)), pick_lid(),
						$urandom());
			end
		end

		wait_idle();
		repeat (20)
			@(posedge clk);
		$display("%0d items in (%0d loads, %0d finishes), %0d results checked",
			items_sent, board.loads, board.finishes, board.results_checked);
		$display("%0d base settings, %0d hits dropped at a full store, %0d ids saturated",
			base_settings, board.dropped, board.saturated);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("timeout with %0d results outstanding", board.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
